[rtl/ugs_pkg.sv]
// ----------------------------------------------------------------------------
// ugs_pkg
// Shared types, register indexes, reset values and arithmetic constants of
// the ultrasonic gate sequencer.
// ----------------------------------------------------------------------------
package ugs_pkg;

    localparam int OP_W     = 2;
    localparam int ECHO_W   = 15;
    localparam int PHASE_W  = 3;
    localparam int ANGLE_W  = 8;
    localparam int PULSE_W  = 11;
    localparam int DIST_W   = 10;
    localparam int THRESH_W = 10;
    localparam int STEP_W   = 8;
    localparam int TIMER_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_ENTRY = 2'd1;
    localparam logic [OP_W-1:0] OP_EXIT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN      = 3'd4;

    localparam logic [THRESH_W-1:0] THRESHOLD_RST = 10'd30;
    localparam logic [STEP_W-1:0]   STEP_RST      = 8'd10;
    localparam logic [TIMER_W-1:0]  HOLD_RST      = 16'd3000;
    localparam logic [TIMER_W-1:0]  COOLDOWN_RST  = 16'd500;
    localparam logic [ANGLE_W-1:0]  OPEN_RST      = 8'd180;

    localparam logic [ANGLE_W-1:0] MAX_ANGLE = 8'd180;

    // distance = (echo * 1124 + 32768) >> 16
    localparam int DIST_PROD_W = 26;
    localparam logic [DIST_PROD_W-1:0] DIST_MUL   = 26'd1124;
    localparam logic [DIST_PROD_W-1:0] DIST_ROUND = 26'd32768;

    // floor(angle * 1000 / 180) == (angle * 364091) >> 16 for angle <= 255
    localparam int PULSE_PROD_W = 27;
    localparam logic [PULSE_PROD_W-1:0] PULSE_MUL  = 27'd364091;
    localparam logic [PULSE_W-1:0]      PULSE_BASE = 11'd1000;

    typedef enum logic [PHASE_W-1:0] {
        PH_CLOSED   = 3'd0,
        PH_OPENING  = 3'd1,
        PH_OPEN     = 3'd2,
        PH_HOLDING  = 3'd3,
        PH_CLOSING  = 3'd4,
        PH_COOLDOWN = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_ENTRY = 2'd1,
        K_EXIT  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [DIST_W-1:0]   dist_cm;
        logic                seen;
    } t_cmd;

    typedef struct packed {
        t_phase              phase;
        logic [ANGLE_W-1:0]  angle;
        logic [PULSE_W-1:0]  pulse;
        logic [DIST_W-1:0]   dist_cm;
        logic                seen;
    } t_res;

    typedef struct packed {
        logic [STEP_W-1:0]   step_period;
        logic [TIMER_W-1:0]  hold_time;
        logic [TIMER_W-1:0]  cooldown;
        logic [ANGLE_W-1:0]  open_angle;
    } t_cfg;

endpackage

[rtl/ugs_fifo.sv]
// ----------------------------------------------------------------------------
// ugs_fifo
// Small register FIFO used between front and back and on the result side.
// ----------------------------------------------------------------------------
module ugs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("fifo count above depth");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("fifo count did not grow on push");

endmodule

[rtl/ugs_front.sv]
// ----------------------------------------------------------------------------
// ugs_front
// Classifies an incoming item: converts echo time to distance and flags a
// vehicle below threshold.
// ----------------------------------------------------------------------------
module ugs_front (
    input  logic [ugs_pkg::OP_W-1:0]     i_op,
    input  logic [ugs_pkg::ECHO_W-1:0]   i_echo_us,
    input  logic                         i_echo_timeout,
    input  logic [ugs_pkg::THRESH_W-1:0] i_threshold,
    output ugs_pkg::t_cmd                o_cmd
);

    logic [ugs_pkg::DIST_PROD_W-1:0] prod;
    logic [ugs_pkg::DIST_W-1:0]      dist_cm;
    logic                            reading;

    assign prod = ugs_pkg::DIST_PROD_W'(i_echo_us) * ugs_pkg::DIST_MUL
                + ugs_pkg::DIST_ROUND;
    assign dist_cm = prod[ugs_pkg::DIST_PROD_W-1:16];

    assign reading = (i_op == ugs_pkg::OP_ENTRY) || (i_op == ugs_pkg::OP_EXIT);

    always_comb begin
        case (i_op)
            ugs_pkg::OP_TICK:  o_cmd.kind = ugs_pkg::K_TICK;
            ugs_pkg::OP_ENTRY: o_cmd.kind = ugs_pkg::K_ENTRY;
            ugs_pkg::OP_EXIT:  o_cmd.kind = ugs_pkg::K_EXIT;
            default:           o_cmd.kind = ugs_pkg::K_NONE;
        endcase
        if (reading && !i_echo_timeout) begin
            o_cmd.dist_cm = dist_cm;
            o_cmd.seen    = (dist_cm < i_threshold);
        end else begin
            o_cmd.dist_cm = '0;
            o_cmd.seen    = 1'b0;
        end
    end

endmodule

[rtl/ugs_back.sv]
// ----------------------------------------------------------------------------
// ugs_back
// Gate phase sequencer: applies ticks and detections, sweeps the servo
// angle and forms the result item.
// ----------------------------------------------------------------------------
module ugs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ugs_pkg::t_cfg  i_cfg,
    input  ugs_pkg::t_cmd  i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  logic           i_res_ready,
    output logic           o_res_push,
    output ugs_pkg::t_res  o_res
);

    ugs_pkg::t_phase                  r_phase, n_phase;
    logic [ugs_pkg::ANGLE_W-1:0]      r_angle, n_angle;
    logic [ugs_pkg::TIMER_W-1:0]      r_ms, n_ms;

    logic                             proc;
    logic [ugs_pkg::TIMER_W-1:0]      ms_inc;
    logic [ugs_pkg::TIMER_W-1:0]      step_per;
    logic                             step_done, hold_done, cool_done;
    logic [ugs_pkg::ANGLE_W-1:0]      eff_open;
    logic [ugs_pkg::PULSE_PROD_W-1:0] pulse_prod;

    assign proc       = i_cmd_valid && i_res_ready;
    assign o_cmd_pop  = proc;
    assign o_res_push = proc;

    assign ms_inc    = r_ms + 1'b1;
    assign step_per  = (i_cfg.step_period == '0) ? ugs_pkg::TIMER_W'(1)
                                                 : ugs_pkg::TIMER_W'(i_cfg.step_period);
    assign step_done = (ms_inc >= step_per) || (ms_inc == '0);
    assign hold_done = (ms_inc >= i_cfg.hold_time) || (ms_inc == '0);
    assign cool_done = (ms_inc >= i_cfg.cooldown) || (ms_inc == '0);

    assign eff_open = (i_cfg.open_angle == '0) ? ugs_pkg::ANGLE_W'(1) :
                      (i_cfg.open_angle > ugs_pkg::MAX_ANGLE) ? ugs_pkg::MAX_ANGLE :
                      i_cfg.open_angle;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (proc) begin
            case (i_cmd.kind)
                ugs_pkg::K_TICK: begin
                    case (r_phase)
                        ugs_pkg::PH_OPENING: begin
                            if (step_done && !(r_angle < eff_open)) begin
                                n_phase = ugs_pkg::PH_OPEN;
                            end
                        end
                        ugs_pkg::PH_HOLDING: begin
                            if (hold_done) n_phase = ugs_pkg::PH_CLOSING;
                        end
                        ugs_pkg::PH_CLOSING: begin
                            if (step_done && (r_angle == '0)) begin
                                n_phase = ugs_pkg::PH_COOLDOWN;
                            end
                        end
                        ugs_pkg::PH_COOLDOWN: begin
                            if (cool_done) n_phase = ugs_pkg::PH_CLOSED;
                        end
                        default: n_phase = r_phase;
                    endcase
                end
                ugs_pkg::K_ENTRY: begin
                    if (i_cmd.seen && (r_phase == ugs_pkg::PH_CLOSED)) begin
                        n_phase = ugs_pkg::PH_OPENING;
                    end
                end
                ugs_pkg::K_EXIT: begin
                    if (i_cmd.seen && (r_phase == ugs_pkg::PH_OPEN)) begin
                        n_phase = ugs_pkg::PH_HOLDING;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // angle and ms counter
    always_comb begin
        n_angle = r_angle;
        n_ms    = r_ms;
        if (proc) begin
            case (i_cmd.kind)
                ugs_pkg::K_TICK: begin
                    case (r_phase)
                        ugs_pkg::PH_OPENING: begin
                            n_ms = step_done ? '0 : ms_inc;
                            if (step_done && (r_angle < eff_open)) begin
                                n_angle = r_angle + 1'b1;
                            end
                        end
                        ugs_pkg::PH_HOLDING:  n_ms = hold_done ? '0 : ms_inc;
                        ugs_pkg::PH_CLOSING: begin
                            n_ms = step_done ? '0 : ms_inc;
                            if (step_done && (r_angle != '0)) begin
                                n_angle = r_angle - 1'b1;
                            end
                        end
                        ugs_pkg::PH_COOLDOWN: n_ms = cool_done ? '0 : ms_inc;
                        default:              n_ms = r_ms;
                    endcase
                end
                ugs_pkg::K_ENTRY: begin
                    if (i_cmd.seen && (r_phase == ugs_pkg::PH_CLOSED)) n_ms = '0;
                end
                ugs_pkg::K_EXIT: begin
                    if (i_cmd.seen && (r_phase == ugs_pkg::PH_OPEN)) n_ms = '0;
                end
                default: n_ms = r_ms;
            endcase
        end
    end

    assign pulse_prod = ugs_pkg::PULSE_PROD_W'(n_angle) * ugs_pkg::PULSE_MUL;

    always_comb begin
        o_res.phase   = n_phase;
        o_res.angle   = n_angle;
        o_res.pulse   = ugs_pkg::PULSE_BASE
                      + ugs_pkg::PULSE_W'(pulse_prod[ugs_pkg::PULSE_PROD_W-1:16]);
        o_res.dist_cm = i_cmd.dist_cm;
        o_res.seen    = i_cmd.seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ugs_pkg::PH_CLOSED;
            r_angle <= '0;
            r_ms    <= '0;
        end else begin
            r_phase <= n_phase;
            r_angle <= n_angle;
            r_ms    <= n_ms;
        end
    end

    a_angle_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_angle <= ugs_pkg::MAX_ANGLE)
        else $error("servo angle above range");

    a_closed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == ugs_pkg::PH_CLOSED) || (r_phase == ugs_pkg::PH_COOLDOWN))
        |-> (r_angle == '0))
        else $error("gate not at zero angle while closed or cooling down");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !proc |=> ($stable(r_phase) && $stable(r_angle) && $stable(r_ms)))
        else $error("sequencer state changed without a transaction");

endmodule

[rtl/ultrasonic_gate_sequencer_core.sv]
// ----------------------------------------------------------------------------
// ultrasonic_gate_sequencer_core
// Barrier gate sequencer driven by 1 ms ticks and ultrasonic echo readings.
// ----------------------------------------------------------------------------
// Input channel: push/full. Each transaction is a tick (op 0), an entry
// reading (op 1) or an exit reading (op 2) with echo time and timeout flag.
// Result channel: empty/pop. Every input transaction yields one result:
// gate phase, servo angle, servo pulse width, distance and vehicle flag.
// Config channel: i_cfg_valid/o_cfg_ready with register index and data;
// always ready, write only while the block is idle.
// Path: the accepting edge writes the classified command into the command
// queue; when the sequencer pops it, the sequencer step is written into the
// result queue, whose head drives the result ports.
// Throughput: one transaction per cycle while the result queue has room;
// the sequencer step has no busy state, so it never holds the flow itself.
// When pop is held low the result queue fills, the sequencer stops, then
// the command queue fills and full rises; nothing is dropped.
// Reset: queues empty, phase closed, angle 0, registers at their defaults.
// ----------------------------------------------------------------------------
module ultrasonic_gate_sequencer_core #(
    parameter int MID_DEPTH = ugs_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = ugs_pkg::OUT_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [ugs_pkg::OP_W-1:0]       i_op,
    input  logic [ugs_pkg::ECHO_W-1:0]     i_echo_us,
    input  logic                           i_echo_timeout,
    output logic                           empty,
    input  logic                           pop,
    output logic [ugs_pkg::PHASE_W-1:0]    o_gate_phase,
    output logic [ugs_pkg::ANGLE_W-1:0]    o_servo_angle,
    output logic [ugs_pkg::PULSE_W-1:0]    o_servo_pulse_us,
    output logic [ugs_pkg::DIST_W-1:0]     o_distance_cm,
    output logic                           o_vehicle_seen,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ugs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ugs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CMD_W = $bits(ugs_pkg::t_cmd);
    localparam int RES_W = $bits(ugs_pkg::t_res);

    logic [ugs_pkg::THRESH_W-1:0] r_threshold;
    ugs_pkg::t_cfg                r_cfg;
    logic                         cfg_wr;

    ugs_pkg::t_cmd    front_cmd;
    logic [CMD_W-1:0] mid_out;
    logic             mid_empty;
    logic             cmd_pop;
    ugs_pkg::t_res    back_res;
    logic             res_push;
    logic             out_full;
    logic [RES_W-1:0] out_data;
    ugs_pkg::t_res    res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold       <= ugs_pkg::THRESHOLD_RST;
            r_cfg.step_period <= ugs_pkg::STEP_RST;
            r_cfg.hold_time   <= ugs_pkg::HOLD_RST;
            r_cfg.cooldown    <= ugs_pkg::COOLDOWN_RST;
            r_cfg.open_angle  <= ugs_pkg::OPEN_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                ugs_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[ugs_pkg::THRESH_W-1:0];
                ugs_pkg::CFG_STEP:      r_cfg.step_period <= i_cfg_data[ugs_pkg::STEP_W-1:0];
                ugs_pkg::CFG_HOLD:      r_cfg.hold_time <= i_cfg_data;
                ugs_pkg::CFG_COOLDOWN:  r_cfg.cooldown <= i_cfg_data;
                ugs_pkg::CFG_OPEN:      r_cfg.open_angle <= i_cfg_data[ugs_pkg::ANGLE_W-1:0];
                default:                r_threshold <= r_threshold;
            endcase
        end
    end

    ugs_front u_front (
        .i_op           (i_op),
        .i_echo_us      (i_echo_us),
        .i_echo_timeout (i_echo_timeout),
        .i_threshold    (r_threshold),
        .o_cmd          (front_cmd)
    );

    ugs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty)
    );

    ugs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (ugs_pkg::t_cmd'(mid_out)),
        .i_cmd_valid (!mid_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_ready (!out_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    ugs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign res              = ugs_pkg::t_res'(out_data);
    assign o_gate_phase     = res.phase;
    assign o_servo_angle    = res.angle;
    assign o_servo_pulse_us = res.pulse;
    assign o_distance_cm    = res.dist_cm;
    assign o_vehicle_seen   = res.seen;

endmodule
